/* src/xdwm_pkg.sv */
`default_nettype none

package xdwm_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WHEEL_SINE   = 2'd0,
      CSR_WHEEL_COSINE = 2'd1,
      CSR_SPEED_SCALE  = 2'd2
   } csr_index_type;

   // Register reset values
   localparam logic signed [15:0] WHEEL_SINE_RESET   = 16'sd0;
   localparam logic signed [15:0] WHEEL_COSINE_RESET = 16'sd16384;
   localparam logic [23:0]        SPEED_SCALE_RESET  = 24'd96510;

   // sqrt(2) in Q30, rounded
   localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;

   // Voltage mode: 10.25*256 on the projected term (sqrt2 already applied),
   // 11*256 on turn, static offsets 1.75 and 1.0 in Q.8
   localparam int VOLT_LIN_GAIN   = 2624;
   localparam int VOLT_TURN_GAIN  = 2816;
   localparam int VOLT_LIN_OFFSET = 448;
   localparam int VOLT_TURN_OFFSET = 256;

   // Wheel geometry and speed scale as seen by the datapath
   typedef struct packed {
      logic signed [15:0] wheel_sine;
      logic signed [15:0] wheel_cosine;
      logic [23:0]        speed_scale;
   } cfg_type;

endpackage

`default_nettype wire

/* src/xdwm_channels.sv */
`default_nettype none

// Command word channel
interface xdwm_req_if;
   logic              valid;
   logic              ready;
   logic              mode;
   logic signed [15:0] x_command;
   logic signed [15:0] y_command;
   logic signed [15:0] turn_command;

   modport source (output valid, mode, x_command, y_command, turn_command, input ready);
   modport sink   (input valid, mode, x_command, y_command, turn_command, output ready);
endinterface

// Drive result word channel
interface xdwm_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] drive_value;
   logic              drive_mode;

   modport source (output valid, drive_value, drive_mode, input ready);
   modport sink   (input valid, drive_value, drive_mode, output ready);
endinterface

// Register write channel
interface xdwm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [xdwm_pkg::CSR_INDEX_W-1:0]    index;
   logic [xdwm_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/xdwm_pipe.sv */
`default_nettype none

module xdwm_pipe #(
   parameter int FRACTION_BITS = 14
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic                in_mode,
   input  wire logic signed [15:0]  in_x,
   input  wire logic signed [15:0]  in_y,
   input  wire logic signed [15:0]  in_t,
   input  wire xdwm_pkg::cfg_type   cfg,
   output logic                     out_valid,
   output logic signed [31:0]       out_value,
   output logic                     out_mode
);

   localparam int NS = 9;                       // register stages
   localparam int AW = 34;                      // projected term after sqrt2
   localparam int TW = 16 + FRACTION_BITS;      // turn aligned to a
   localparam int DW = ((AW > TW) ? AW : TW) + 1;
   localparam int LB = 18;                      // low slice of d for the split multiply
   localparam int HW = DW - LB;
   localparam int VW = DW + 25;                 // full Q(2F+8) value

   localparam logic signed [31:0] ONE     = 32'sd1 <<< FRACTION_BITS;
   localparam logic signed [31:0] NEG_ONE = -ONE;
   localparam logic signed [63:0] HALF_A  = 64'sd1 <<< 29;
   localparam logic signed [VW-1:0] HALF_V = VW'(1) <<< (2 * FRACTION_BITS - 1);
   localparam logic signed [VW-1:0] GAIN_LIN  = VW'(xdwm_pkg::VOLT_LIN_GAIN);
   localparam logic signed [VW-1:0] GAIN_TURN = VW'(xdwm_pkg::VOLT_TURN_GAIN);
   localparam logic signed [VW-1:0] LIN_OFS  =
      VW'(xdwm_pkg::VOLT_LIN_OFFSET) <<< (2 * FRACTION_BITS);
   localparam logic signed [VW-1:0] TURN_OFS =
      VW'(xdwm_pkg::VOLT_TURN_OFFSET) <<< (2 * FRACTION_BITS);
   localparam logic signed [VW-1:0] OUT_MAX = VW'(2147483647);
   localparam logic signed [VW-1:0] OUT_MIN = -OUT_MAX - VW'(1);

   function automatic logic signed [15:0] clamp_one(input logic signed [15:0] v);
      logic signed [31:0] w;
      logic signed [15:0] r;
      w = 32'(v);
      if (w > ONE) r = ONE[15:0];
      else if (w < NEG_ONE) r = NEG_ONE[15:0];
      else r = v;
      return r;
   endfunction

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] mode_ff;

   logic signed [15:0]   x1_ff, y1_ff, t1_ff, x1_in, y1_in, t1_in;
   logic signed [31:0]   px2_ff, py2_ff, px2_in, py2_in;
   logic signed [15:0]   t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic signed [32:0]   lin3_ff, lin3_in;
   logic signed [63:0]   p4_ff, p4_in, p_round;
   logic                 lp4_ff, ln4_ff, lp5_ff, ln5_ff, lp6_ff, ln6_ff;
   logic                 lp4_in, ln4_in;
   logic signed [AW-1:0] a5_ff, a5_in, a6_ff;
   logic signed [DW-1:0] d6_ff, d6_in;
   logic signed [VW-1:0] vol7_ff, vol7_in, lin_ofs, turn_ofs;
   logic signed [HW+24:0] hi7_ff, hi7_in;
   logic [LB+23:0]       lo7_ff, lo7_in;
   logic signed [VW-1:0] v8_ff, v8_in, vel;
   logic signed [VW-1:0] sh;
   logic signed [31:0]   value9_ff, value9_in;

   // Stage 1: clamp each command to plus or minus one
   always_comb begin
      x1_in = clamp_one(in_x);
      y1_in = clamp_one(in_y);
      t1_in = clamp_one(in_t);
   end

   // Stage 2: project onto the wheel axis
   always_comb begin
      px2_in = 32'(cfg.wheel_cosine) * 32'(x1_ff);
      py2_in = 32'(cfg.wheel_sine) * 32'(y1_ff);
   end

   // Stage 3: sum of projections
   assign lin3_in = 33'(px2_ff) + 33'(py2_ff);

   // Stage 4: scale by sqrt2, keep sign of the projection
   always_comb begin
      p4_in  = 64'(lin3_ff) * 64'(xdwm_pkg::SQRT2_Q30);
      lp4_in = !lin3_ff[32] && (|lin3_ff);
      ln4_in = lin3_ff[32];
   end

   // Stage 5: round off the Q30 fraction
   always_comb begin
      p_round = p4_ff + HALF_A;
      a5_in   = p_round[63:30];
   end

   // Stage 6: velocity difference term
   assign d6_in = DW'(a5_ff) - (DW'(t5_ff) <<< FRACTION_BITS);

   // Stage 7: velocity partial products and the voltage sum
   always_comb begin
      hi7_in = (HW+25)'($signed(d6_ff[DW-1:LB]))
             * (HW+25)'($signed({1'b0, cfg.speed_scale}));
      lo7_in = (LB+24)'(d6_ff[LB-1:0]) * (LB+24)'(cfg.speed_scale);
      if (lp6_ff) lin_ofs = LIN_OFS;
      else if (ln6_ff) lin_ofs = -LIN_OFS;
      else lin_ofs = '0;
      if (!t6_ff[15] && (|t6_ff)) turn_ofs = TURN_OFS;
      else if (t6_ff[15]) turn_ofs = -TURN_OFS;
      else turn_ofs = '0;
      vol7_in = VW'(a6_ff) * GAIN_LIN + lin_ofs
              - ((VW'(t6_ff) * GAIN_TURN) <<< FRACTION_BITS) + turn_ofs;
   end

   // Stage 8: merge partial products, pick mode, add rounding half
   always_comb begin
      vel   = (VW'(hi7_ff) <<< LB) + $signed(VW'(lo7_ff));
      v8_in = (mode_ff[6] ? vol7_ff : vel) + HALF_V;
   end

   // Stage 9: drop the Q(2F) fraction and saturate to 32 bits
   always_comb begin
      sh = v8_ff >>> (2 * FRACTION_BITS);
      if (sh > OUT_MAX) value9_in = OUT_MAX[31:0];
      else if (sh < OUT_MIN) value9_in = OUT_MIN[31:0];
      else value9_in = sh[31:0];
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff   <= {mode_ff[NS-2:0], in_mode};
         x1_ff     <= x1_in;
         y1_ff     <= y1_in;
         t1_ff     <= t1_in;
         px2_ff    <= px2_in;
         py2_ff    <= py2_in;
         t2_ff     <= t1_ff;
         lin3_ff   <= lin3_in;
         t3_ff     <= t2_ff;
         p4_ff     <= p4_in;
         lp4_ff    <= lp4_in;
         ln4_ff    <= ln4_in;
         t4_ff     <= t3_ff;
         a5_ff     <= a5_in;
         lp5_ff    <= lp4_ff;
         ln5_ff    <= ln4_ff;
         t5_ff     <= t4_ff;
         a6_ff     <= a5_ff;
         d6_ff     <= d6_in;
         lp6_ff    <= lp5_ff;
         ln6_ff    <= ln5_ff;
         t6_ff     <= t5_ff;
         vol7_ff   <= vol7_in;
         hi7_ff    <= hi7_in;
         lo7_ff    <= lo7_in;
         v8_ff     <= v8_in;
         value9_ff <= value9_in;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_value = value9_ff;
   assign out_mode  = mode_ff[NS-1];

   // A frozen pipe keeps its occupancy
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipe occupancy changed while stalled");

   // An accepted word lands in the first stage
   a_entry: assert property (@(posedge clock) disable iff (reset)
      en && in_valid |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   // Clamped commands stay within plus or minus one
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (32'(x1_ff) <= ONE) && (32'(x1_ff) >= NEG_ONE)
                   && (32'(y1_ff) <= ONE) && (32'(y1_ff) >= NEG_ONE)
                   && (32'(t1_ff) <= ONE) && (32'(t1_ff) >= NEG_ONE))
      else $error("clamp out of range");

endmodule

`default_nettype wire

/* src/xdrive_wheel_command_mixer.sv */
// X-drive wheel command mixer. Each command word (mode, x, y, turn in Q2.14)
// is clamped to plus or minus one, projected onto the wheel axis with the
// programmed sine and cosine, and turned into one drive value in Q.8: a
// velocity scaled by sqrt2 times speed_scale with turn subtracted, or a
// voltage with fixed gains and static offsets, saturated to 32 bits. The
// block takes one word per clock unless the result side stalls and returns
// each result in order; the nine stages are set by the projection
// multipliers, the sqrt2 multiply, the split speed_scale multiply and the
// final rounding and saturation. When the result side stalls the whole pipe
// holds, so req_ch.ready follows rsp_ch.ready combinationally once a result
// is waiting. The user must write registers only while no word is in flight;
// the block itself does not enforce this. The register port is always ready.
`default_nettype none

module xdrive_wheel_command_mixer #(
   parameter int FRACTION_BITS = 14
) (
   input wire logic clock,
   input wire logic reset,
   xdwm_req_if.sink   req_ch,
   xdwm_rsp_if.source rsp_ch,
   xdwm_csr_if.sink   csr_ch
);

   xdwm_pkg::cfg_type cfg_ff, cfg_in;
   logic              en;
   logic              pipe_valid;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (xdwm_pkg::csr_index_type'(csr_ch.index))
            xdwm_pkg::CSR_WHEEL_SINE:   cfg_in.wheel_sine   = csr_ch.data[15:0];
            xdwm_pkg::CSR_WHEEL_COSINE: cfg_in.wheel_cosine = csr_ch.data[15:0];
            xdwm_pkg::CSR_SPEED_SCALE:  cfg_in.speed_scale  = csr_ch.data[23:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_sine   <= xdwm_pkg::WHEEL_SINE_RESET;
         cfg_ff.wheel_cosine <= xdwm_pkg::WHEEL_COSINE_RESET;
         cfg_ff.speed_scale  <= xdwm_pkg::SPEED_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ch.ready = 1'b1;

   // Pipe advances unless a finished word is waiting
   assign en           = !pipe_valid || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = pipe_valid;

   xdwm_pipe #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_mode   (req_ch.mode),
      .in_x      (req_ch.x_command),
      .in_y      (req_ch.y_command),
      .in_t      (req_ch.turn_command),
      .cfg       (cfg_ff),
      .out_valid (pipe_valid),
      .out_value (rsp_ch.drive_value),
      .out_mode  (rsp_ch.drive_mode)
   );

endmodule

`default_nettype wire
